### rtl/core/ppi_pkg.sv
package ppi_pkg;

    localparam int CNT_W       = 11;
    localparam int STAMP_W     = 64;
    localparam int GAP_W       = 30;
    localparam int FALL_W      = 32;
    localparam int MAX_PACKETS = 1024;
    localparam int DIV_W       = $clog2(MAX_PACKETS);
    localparam int STEP_W      = $clog2(GAP_W);
    localparam int MIN_PACED   = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [FALL_W-1:0] FALLBACK_RESET = FALL_W'(0);
    localparam logic [GAP_W-1:0]  MAX_WIN_RESET  = GAP_W'(2000000);
    localparam logic [GAP_W-1:0]  MIN_INT_RESET  = GAP_W'(50000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FALLBACK = 2'd0,
        CFG_MAX_WIN  = 2'd1,
        CFG_MIN_INT  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        logic             bypass;
        logic [GAP_W-1:0] window;
        logic [DIV_W-1:0] divisor;
    } job_t;

    typedef struct packed {
        logic div_busy;
        logic out_valid;
    } back_status_t;

endpackage

### rtl/core/ppi_front.sv
module ppi_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ppi_pkg::CNT_W-1:0]    pkt_count,
    input  logic [ppi_pkg::STAMP_W-1:0]  capture_time_ns,
    input  logic [ppi_pkg::FALL_W-1:0]   fallback_interval_ns,
    input  logic [ppi_pkg::GAP_W-1:0]    max_window_ns,
    input  logic [ppi_pkg::GAP_W-1:0]    min_interval_ns,
    output logic                         job_valid,
    input  logic                         job_ready,
    output ppi_pkg::job_t                job
);

    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic                         s1_few_reg;
    logic [ppi_pkg::STAMP_W-1:0]  s1_interval_reg;
    logic [ppi_pkg::DIV_W-1:0]    s1_divisor_reg;
    logic [ppi_pkg::STAMP_W-1:0]  last_capture_reg;
    logic [ppi_pkg::STAMP_W-1:0]  last_capture_next;
    logic [ppi_pkg::STAMP_W-1:0]  interval;
    logic [ppi_pkg::CNT_W-1:0]    count_sat;
    logic [ppi_pkg::GAP_W-1:0]    window;
    logic                         accept;

    assign in_ready  = !s1_valid_reg || job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = s1_valid_reg;

    always_comb
    begin
        interval = ppi_pkg::STAMP_W'(fallback_interval_ns);
        if ((capture_time_ns != '0) && (last_capture_reg != '0)
            && (capture_time_ns > last_capture_reg))
        begin
            interval = capture_time_ns - last_capture_reg;
        end
        if (pkt_count > ppi_pkg::CNT_W'(ppi_pkg::MAX_PACKETS))
        begin
            count_sat = ppi_pkg::CNT_W'(ppi_pkg::MAX_PACKETS);
        end
        else
        begin
            count_sat = pkt_count;
        end
        last_capture_next = last_capture_reg;
        if (accept && (capture_time_ns != '0))
        begin
            last_capture_next = capture_time_ns;
        end
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (job_ready)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            last_capture_reg <= '0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            last_capture_reg <= last_capture_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_few_reg      <= pkt_count < ppi_pkg::CNT_W'(ppi_pkg::MIN_PACED);
            s1_interval_reg <= interval;
            s1_divisor_reg  <= ppi_pkg::DIV_W'(count_sat - ppi_pkg::CNT_W'(1));
        end
    end

    // classify: pacing off, or a division job for the back end
    always_comb
    begin
        if (s1_interval_reg[ppi_pkg::STAMP_W-1:2]
            > (ppi_pkg::STAMP_W-2)'(max_window_ns))
        begin
            window = max_window_ns;
        end
        else
        begin
            window = s1_interval_reg[ppi_pkg::GAP_W+1:2];
        end
        job.window  = window;
        job.divisor = s1_divisor_reg;
        job.bypass  = s1_few_reg || (s1_interval_reg == '0)
                      || (window < min_interval_ns);
    end

endmodule

### rtl/core/ppi_queue.sv
module ppi_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          push_ready,
    input  ppi_pkg::job_t push_data,
    input  logic          pop,
    output logic          pop_valid,
    output ppi_pkg::job_t pop_data
);

    ppi_pkg::job_t                mem_reg [ppi_pkg::QDEPTH];
    logic [ppi_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [ppi_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [ppi_pkg::QCNT_W-1:0]   count_reg;
    logic [ppi_pkg::QCNT_W-1:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = count_reg != ppi_pkg::QCNT_W'(ppi_pkg::QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + ppi_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - ppi_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + ppi_pkg::QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + ppi_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/ppi_back.sv
module ppi_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      job_valid,
    output logic                      job_pop,
    input  ppi_pkg::job_t             job,
    input  logic [ppi_pkg::GAP_W-1:0] min_interval_ns,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ppi_pkg::GAP_W-1:0] gap_ns,
    output ppi_pkg::back_status_t     status
);

    ppi_pkg::back_state_t         state_reg;
    ppi_pkg::back_state_t         state_next;
    logic [ppi_pkg::DIV_W-1:0]    rem_reg;
    logic [ppi_pkg::DIV_W-1:0]    rem_next;
    logic [ppi_pkg::GAP_W-1:0]    quo_reg;
    logic [ppi_pkg::GAP_W-1:0]    quo_next;
    logic [ppi_pkg::DIV_W-1:0]    div_reg;
    logic [ppi_pkg::DIV_W-1:0]    div_next;
    logic [ppi_pkg::STEP_W-1:0]   step_reg;
    logic [ppi_pkg::STEP_W-1:0]   step_next;
    logic [ppi_pkg::GAP_W-1:0]    gap_reg;
    logic [ppi_pkg::GAP_W-1:0]    gap_next;
    logic [ppi_pkg::DIV_W:0]      trial;
    logic [ppi_pkg::DIV_W:0]      diff;
    logic                         qbit;
    logic [ppi_pkg::GAP_W-1:0]    quo_shift;

    assign gap_ns    = gap_reg;
    assign out_valid = state_reg == ppi_pkg::ST_OUT;
    assign status    = {state_reg == ppi_pkg::ST_DIV, out_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ppi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        div_reg  <= div_next;
        step_reg <= step_next;
        gap_reg  <= gap_next;
    end

    always_comb
    begin
        trial      = {rem_reg, quo_reg[ppi_pkg::GAP_W-1]};
        diff       = trial - {1'b0, div_reg};
        qbit       = trial >= {1'b0, div_reg};
        quo_shift  = {quo_reg[ppi_pkg::GAP_W-2:0], qbit};
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        div_next   = div_reg;
        step_next  = step_reg;
        gap_next   = gap_reg;
        job_pop    = 1'b0;
        case (state_reg)
            ppi_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    if (job.bypass)
                    begin
                        gap_next   = '0;
                        state_next = ppi_pkg::ST_OUT;
                    end
                    else
                    begin
                        rem_next   = '0;
                        quo_next   = job.window;
                        div_next   = job.divisor;
                        step_next  = '0;
                        state_next = ppi_pkg::ST_DIV;
                    end
                end
            end
            ppi_pkg::ST_DIV:
            begin
                // one restoring step per cycle, quotient bits shift in from the right
                rem_next  = qbit ? diff[ppi_pkg::DIV_W-1:0] : trial[ppi_pkg::DIV_W-1:0];
                quo_next  = quo_shift;
                step_next = step_reg + ppi_pkg::STEP_W'(1);
                if (step_reg == ppi_pkg::STEP_W'(ppi_pkg::GAP_W - 1))
                begin
                    gap_next   = (quo_shift < min_interval_ns) ? '0 : quo_shift;
                    state_next = ppi_pkg::ST_OUT;
                end
            end
            ppi_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ppi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppi_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/packet_pacing_interval_top.sv
// Packet pacing gap per video frame. Each input request carries the frame's packet
// count and capture timestamp (0 = none); each one yields exactly one gap_ns result,
// 0 meaning send without pacing. An accepted frame is registered in the front stage,
// classified there and queued as a job; the back end takes the job from the queue,
// and the one-bit-per-cycle restoring divider splits the window over count - 1
// gaps, its last step loading the output register. The divider works on one frame
// at a time; while it is busy, the front stage and the two-entry queue hold further
// frames. Frames that need no division skip the divider; the back end loads a zero
// result into the output register. Configuration writes are always taken.
module packet_pacing_interval_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [79:0]                      s_axis_tdata,  // pkt_count, capture_time_ns
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [31:0]                      m_axis_tdata,  // gap_ns
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ppi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppi_pkg::CFG_DATA_W-1:0]   cfg_data
);

    logic [ppi_pkg::FALL_W-1:0]  fallback_reg;
    logic [ppi_pkg::GAP_W-1:0]   max_window_reg;
    logic [ppi_pkg::GAP_W-1:0]   min_interval_reg;
    logic                        front_valid;
    logic                        front_ready;
    ppi_pkg::job_t               front_job;
    logic                        q_valid;
    logic                        q_pop;
    ppi_pkg::job_t               q_job;
    logic [ppi_pkg::GAP_W-1:0]   gap;
    ppi_pkg::back_status_t       back_status;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = {2'b00, gap};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fallback_reg     <= ppi_pkg::FALLBACK_RESET;
            max_window_reg   <= ppi_pkg::MAX_WIN_RESET;
            min_interval_reg <= ppi_pkg::MIN_INT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ppi_pkg::CFG_FALLBACK: fallback_reg     <= cfg_data;
                ppi_pkg::CFG_MAX_WIN:  max_window_reg   <= cfg_data[ppi_pkg::GAP_W-1:0];
                ppi_pkg::CFG_MIN_INT:  min_interval_reg <= cfg_data[ppi_pkg::GAP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ppi_front u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (s_axis_tvalid),
        .in_ready             (s_axis_tready),
        .pkt_count            (s_axis_tdata[10:0]),
        .capture_time_ns      (s_axis_tdata[74:11]),
        .fallback_interval_ns (fallback_reg),
        .max_window_ns        (max_window_reg),
        .min_interval_ns      (min_interval_reg),
        .job_valid            (front_valid),
        .job_ready            (front_ready),
        .job                  (front_job)
    );

    ppi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_valid),
        .push_ready (front_ready),
        .push_data  (front_job),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_job)
    );

    ppi_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (q_valid),
        .job_pop         (q_pop),
        .job             (q_job),
        .min_interval_ns (min_interval_reg),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .gap_ns          (gap),
        .status          (back_status)
    );

`ifndef NO_ASSERTIONS
    a_no_result_during_div: assert property (@(posedge clk) disable iff (!rst_n)
        !(back_status.div_busy && m_axis_tvalid))
        else $error("result shown while divider busy");

    a_no_pop_while_output: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !q_pop)
        else $error("job taken while result pending");

    a_cfg_min_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == ppi_pkg::CFG_MIN_INT))
        |=> (min_interval_reg == $past(cfg_data[ppi_pkg::GAP_W-1:0])))
        else $error("min interval write lost");
`endif

endmodule

### bench/tb_packet_pacing_interval_top.sv
`timescale 1ns / 1ps

module tb_packet_pacing_interval_top;

    import ppi_pkg::*;

    localparam int CYCLE_LIMIT  = 250000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_FRAMES = 75;
    localparam int PHASES       = 6;

    typedef struct packed {
        logic [CNT_W-1:0]   count;
        logic [STAMP_W-1:0] stamp;
        logic               known;
        logic [GAP_W-1:0]   gap;
    } frame_row_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [79:0]           s_axis_tdata  = '0;  // pkt_count, capture_time_ns
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;        // gap_ns
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    logic [FALL_W-1:0]  fallback_ns   = FALLBACK_RESET;
    logic [GAP_W-1:0]   window_cap_ns = MAX_WIN_RESET;
    logic [GAP_W-1:0]   gap_floor_ns  = MIN_INT_RESET;
    logic [STAMP_W-1:0] last_stamp_ns = '0;

    logic [GAP_W-1:0]   gap_queue [$];
    frame_row_t         directed_rows [$];
    logic               frame_known   = 1'b0;
    logic [GAP_W-1:0]   frame_gap     = '0;
    logic [STAMP_W-1:0] frame_clock_ns = '0;

    int send_idle_pct  = 29;
    int recv_idle_pct  = 85;
    int mismatch_count = 0;
    int cycle_count    = 0;

    packet_pacing_interval_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // pacing gap for one frame; advances the stored capture stamp
    function automatic logic [GAP_W-1:0] pace_gap(input logic [CNT_W-1:0] count,
                                                  input logic [STAMP_W-1:0] stamp);
        logic [63:0] interval;
        logic [63:0] window;
        logic [63:0] parts;
        logic [63:0] gap;
        if (count < CNT_W'(MIN_PACED))
        begin
            if (stamp != '0)
                last_stamp_ns = stamp;
            return '0;
        end
        interval = {32'd0, fallback_ns};
        if (stamp != '0)
        begin
            if (last_stamp_ns != '0 && stamp > last_stamp_ns)
                interval = stamp - last_stamp_ns;
            last_stamp_ns = stamp;
        end
        if (interval == 64'd0)
            return '0;
        window = interval >> 2;
        if (window > {34'd0, window_cap_ns})
            window = {34'd0, window_cap_ns};
        if (window < {34'd0, gap_floor_ns})
            return '0;
        parts = (count > CNT_W'(MAX_PACKETS)) ? 64'(MAX_PACKETS) : {53'd0, count};
        gap = window / (parts - 64'd1);
        if (gap < {34'd0, gap_floor_ns})
            return '0;
        return gap[GAP_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] gap mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
    begin : track_gaps
        logic [GAP_W-1:0] want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (gap_queue.size() == 0)
                    report_mismatch($sformatf("gap %0d with no request pending",
                                              m_axis_tdata[GAP_W-1:0]));
                else
                begin
                    want = gap_queue.pop_front();
                    if (m_axis_tdata[GAP_W-1:0] !== want)
                        report_mismatch($sformatf("got %0d, expected %0d",
                                                  m_axis_tdata[GAP_W-1:0], want));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FALLBACK: fallback_ns   = cfg_data[FALL_W-1:0];
                    CFG_MAX_WIN:  window_cap_ns = cfg_data[GAP_W-1:0];
                    CFG_MIN_INT:  gap_floor_ns  = cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                want = pace_gap(s_axis_tdata[CNT_W-1:0], s_axis_tdata[CNT_W +: STAMP_W]);
                if (frame_known)
                    want = frame_gap;
                gap_queue.push_back(want);
            end
        end
    end

    task automatic send_frame(input frame_row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, row.stamp, row.count};
        frame_known   <= row.known;
        frame_gap     <= row.gap;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // hold requests until every pending gap has come back
    task automatic drain_frames();
        s_axis_tvalid <= 1'b0;
        wait (gap_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_setting(input int setting);
        logic [CFG_DATA_W-1:0] fallback;
        logic [CFG_DATA_W-1:0] window_cap;
        logic [CFG_DATA_W-1:0] gap_floor;
        case (setting)
            0:
            begin
                fallback   = $urandom_range(10_000_000, 50_000_000);
                window_cap = 32'd2_000_000;
                gap_floor  = 32'd50_000;
            end
            1:
            begin
                fallback   = 32'd0;
                window_cap = 32'd1_000_000_000;
                gap_floor  = 32'd0;
            end
            2:
            begin
                fallback   = 32'hFFFF_FFFF;
                window_cap = 32'hFFFF_FFFF;
                gap_floor  = 32'hFFFF_FFFF;
            end
            3:
            begin
                fallback   = 32'd33_333_333;
                window_cap = 32'd0;
                gap_floor  = 32'd0;
            end
            4:
            begin
                fallback   = $urandom;
                window_cap = $urandom_range(0, 1_000_000_000);
                gap_floor  = $urandom_range(0, 200_000);
            end
            default:
            begin
                fallback   = 32'd40_000_000;
                window_cap = 32'd10_000_000;
                gap_floor  = 32'd1_000;
            end
        endcase
        write_reg(CFG_MAX_WIN, window_cap);
        write_reg(CFG_FALLBACK, fallback);
        write_reg(CFG_MIN_INT, gap_floor);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [STAMP_W-1:0] stamp_step();
        case ($urandom_range(2))
            0:       return 64'($urandom_range(1, 400_000));
            1:       return 64'($urandom_range(1, 80_000_000));
            default: return 64'($urandom);
        endcase
    endfunction

    task automatic random_frame();
        frame_row_t row;
        int         pick;
        pick      = $urandom_range(99);
        row.known = 1'b0;
        row.gap   = '0;
        row.count = CNT_W'($urandom_range(4, 48));
        if ($urandom_range(9) == 0)
            row.count = CNT_W'($urandom_range(0, 2047));
        if (pick < 70)
        begin
            frame_clock_ns = frame_clock_ns + stamp_step();
            row.stamp      = frame_clock_ns;
        end
        else if (pick < 78)
        begin
            row.count      = CNT_W'($urandom_range(0, 3));
            frame_clock_ns = frame_clock_ns + stamp_step();
            row.stamp      = frame_clock_ns;
        end
        else if (pick < 86)
            row.stamp = '0;
        else if (pick < 93)
        begin
            row.stamp      = frame_clock_ns - 64'($urandom_range(0, 5000));
            frame_clock_ns = row.stamp;
        end
        else
        begin
            row.stamp      = {$urandom, $urandom};
            row.count      = CNT_W'($urandom_range(0, 2047));
            frame_clock_ns = row.stamp;
        end
        send_frame(row);
    endtask

    initial
    begin : stimulus
        int phase;
        int n;

        // reset settings: no fallback, window cap 2 ms, floor 50 us
        directed_rows.push_back(frame_row_t'{11'd0, 64'd0, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd4, 64'd5_000, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd3, 64'd1_000, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd4, 64'd0, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd4, 64'd40_001_000, 1'b0, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd1024, 64'd80_001_000, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd2047, 64'd120_001_000, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd40, 64'd160_001_000, 1'b0, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd41, 64'd200_001_000, 1'b1, 30'd50_000});
        directed_rows.push_back(frame_row_t'{11'd42, 64'd240_001_000, 1'b0, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd4, 64'd240_001_000, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd4, 64'd100, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd4, 64'd300_100, 1'b0, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd4, 64'd500_100, 1'b0, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd4, 64'd699_100, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd5, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 30'd500_000});
        directed_rows.push_back(frame_row_t'{11'd3, 64'd0, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd4, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd1, 64'h5555_5555_5555_5555, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'd1025, 64'hAAAA_AAAA_AAAA_AAAB, 1'b1, 30'd0});
        directed_rows.push_back(frame_row_t'{11'h7FF, 64'hAAAA_AAAA_AAAA_AAAB, 1'b1, 30'd0});

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_frame(directed_rows[i]);

        for (phase = 0; phase < PHASES; phase++)
        begin
            drain_frames();
            if (phase == 2)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 29;
            end
            else if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_setting(phase);
            for (n = 0; n < PHASE_FRAMES; n++)
            begin
                if (n == PHASE_FRAMES / 2)
                    drain_frames();
                random_frame();
            end
        end

        drain_frames();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
